[rtl/core/tgc_pkg.sv]
// Shared types and constants of the turning-grille cipher.
// Used by every module of the block but the checker, and by the testbench; depends on nothing.
package tgc_pkg;

  localparam int unsigned TGC_GRID_SIDE = 8;
  localparam int unsigned NUM_CELLS     = 64;

  localparam logic [63:0] HOLE_MASK_RESET = 64'hD8DC_8F14_0000_0000;
  localparam logic [31:0] PAD_SEED_RESET  = 32'd1;
  localparam logic [31:0] PAD_TAPS        = 32'h8020_0003;
  localparam logic [31:0] PAD_RECIP       = 32'h9D89_D89E;
  localparam logic [7:0]  CHR_LOWER_A     = 8'h61;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_MASK = 2'd1;
  localparam logic [1:0] CFG_SEED = 2'd2;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic ACT_DATA   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [1:0] ROT_LAST = 2'd3;
  localparam logic [5:0] POS_LAST = 6'd63;

  typedef struct packed {
    logic       hit;
    logic [5:0] pos;
    logic       more;
  } scan_t;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
  } rd_req_t;

endpackage

[rtl/core/tgc_store.sv]
// Cell store: 64 x 8 synchronous memory with registered read and per-entry valid bits.
// Depends on tgc_pkg.
module tgc_store
  import tgc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_wr_t    wr_i,
  input  logic       clear_i,
  input  rd_req_t    rd_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]  mem [NUM_CELLS];
  logic [63:0] vld_q;
  logic [7:0]  rd_q;
  logic        rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_q     <= mem[rd_i.addr];
      rd_vld_q <= vld_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : 8'h00;

endmodule

[rtl/core/tgc_scan.sv]
// Hole scan: hole vector of one grille rotation and first hole at or after a position.
// Depends on tgc_pkg.
module tgc_scan
  import tgc_pkg::*;
#(
  parameter int unsigned GRID_SIDE = TGC_GRID_SIDE
) (
  input  logic [63:0] mask_i,
  input  logic [1:0]  rot_i,
  input  logic [5:0]  pos_i,
  output scan_t       scan_o
);

  function automatic logic [63:0] hole_vec(input logic [63:0] mask, input logic [1:0] rot);
    logic [63:0] hv;
    logic [2:0]  r;
    logic [2:0]  c;
    logic [2:0]  nr;
    logic        ok;
    hv = '0;
    for (int p = 0; p < 64; p++) begin
      r  = 3'(p >> 3);
      c  = 3'(p & 7);
      ok = (32'(r) < GRID_SIDE) && (32'(c) < GRID_SIDE);
      for (int k = 0; k < 3; k++) begin
        if (k < int'(rot)) begin
          nr = 3'(GRID_SIDE - 1) - c;
          c  = r;
          r  = nr;
        end
      end
      hv[p] = ok && mask[{r, c}];
    end
    return hv;
  endfunction

  logic [63:0] hv;
  logic [63:0] cand;
  logic [63:0] beyond;
  logic [5:0]  first;

  assign hv   = hole_vec(mask_i, rot_i);
  assign cand = hv & ({64{1'b1}} << pos_i);

  always_comb begin
    first = '0;
    for (int p = 63; p >= 0; p--) begin
      if (cand[p]) begin
        first = 6'(p);
      end
    end
  end

  assign beyond = hv & (({64{1'b1}} << first) << 1);

  assign scan_o.hit  = |cand;
  assign scan_o.pos  = first;
  assign scan_o.more = (|beyond) || ((rot_i != ROT_LAST) && (|hv));

endmodule

[rtl/core/tgc_pad.sv]
// Padding letter source: Galois LFSR and modulo-26 by reciprocal multiply.
// Depends on tgc_pkg.
module tgc_pad
  import tgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] seed_i,
  input  logic        step_i,
  output logic [7:0]  letter_o
);

  logic [31:0] lfsr_q;
  logic [31:0] lfsr_d;
  logic [27:0] quo_q;
  logic [31:0] base;
  logic [63:0] prod;
  logic [31:0] rem;

  assign base   = (lfsr_q == '0) ? 32'd1 : lfsr_q;
  assign lfsr_d = (base >> 1) ^ (base[0] ? PAD_TAPS : 32'h0);
  assign prod   = {32'h0, lfsr_d} * {32'h0, PAD_RECIP};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= PAD_SEED_RESET;
    end else if (load_i) begin
      lfsr_q <= seed_i;
    end else if (step_i) begin
      lfsr_q <= lfsr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      quo_q <= prod[63:36];
    end
  end

  assign rem      = lfsr_q - 32'({4'h0, quo_q} * 32'd26);
  assign letter_o = CHR_LOWER_A + {3'b000, rem[4:0]};

endmodule

[rtl/core/tgc_ctrl.sv]
// Sequencer of the turning-grille cipher: filter, placement, padding and emission.
// Depends on tgc_pkg; drives tgc_store, tgc_scan and tgc_pad.
module tgc_ctrl
  import tgc_pkg::*;
#(
  parameter int unsigned GRID_SIDE = TGC_GRID_SIDE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_action_i,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  out_index_o,
  output logic        out_last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic [63:0] mask_o,
  output logic [1:0]  scan_rot_o,
  output logic [5:0]  scan_pos_o,
  input  scan_t       scan_i,
  output mem_wr_t     wr_o,
  output logic        clear_o,
  output rd_req_t     rd_o,
  output logic        pad_load_o,
  output logic [31:0] pad_seed_o,
  output logic        pad_step_o,
  input  logic [7:0]  pad_letter_i
);

  localparam logic [6:0] Total    = 7'(GRID_SIDE * GRID_SIDE);
  localparam logic [6:0] CellsMax = 7'(NUM_CELLS);
  localparam logic [2:0] SideLast = 3'(GRID_SIDE - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_SCAN,
    ST_PAD_SCAN,
    ST_PAD_WRITE,
    ST_ENC_EMIT,
    ST_DEC_EMIT
  } state_e;

  function automatic logic dropped(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D) ||
           (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
           (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
  endfunction

  state_e      state_q, state_d;
  logic        mode_q, mode_d;
  logic [63:0] mask_q, mask_d;
  logic [7:0]  byte_q, byte_d;
  logic [1:0]  rot_q, rot_d;
  logic [5:0]  pos_q, pos_d;
  logic [6:0]  placed_q, placed_d;
  logic [2:0]  row_q, row_d;
  logic [2:0]  col_q, col_d;
  logic [1:0]  s_rot_q, s_rot_d;
  logic [5:0]  s_pos_q, s_pos_d;
  logic [5:0]  pad_addr_q, pad_addr_d;
  logic        pad_more_q, pad_more_d;
  logic [5:0]  n_q, n_d;
  logic        out_valid_q, out_valid_d;
  logic [5:0]  out_idx_q, out_idx_d;
  logic        out_last_q, out_last_d;

  logic       accept;
  logic       slot_free;
  logic [6:0] placed_inc;
  logic       grid_last;
  logic       dec_last;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign placed_inc = placed_q + 7'd1;
  assign grid_last  = (row_q == SideLast) && (col_q == SideLast);
  assign dec_last   = (n_q == POS_LAST) || !scan_i.more;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    mask_d      = mask_q;
    byte_d      = byte_q;
    rot_d       = rot_q;
    pos_d       = pos_q;
    placed_d    = placed_q;
    row_d       = row_q;
    col_d       = col_q;
    s_rot_d     = s_rot_q;
    s_pos_d     = s_pos_q;
    pad_addr_d  = pad_addr_q;
    pad_more_d  = pad_more_q;
    n_d         = n_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    wr_o        = '0;
    rd_o        = '0;
    clear_o     = 1'b0;
    pad_step_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_q == MODE_ENC) begin
            s_rot_d = rot_q;
            s_pos_d = pos_q;
            if (in_action_i == ACT_FINISH) begin
              state_d = ST_PAD_SCAN;
            end else if (!dropped(in_byte_i)) begin
              byte_d  = lower(in_byte_i);
              state_d = ST_ENC_SCAN;
            end
          end else if (in_action_i == ACT_FINISH) begin
            s_rot_d = '0;
            s_pos_d = '0;
            n_d     = '0;
            state_d = ST_DEC_EMIT;
          end else begin
            wr_o.en   = 1'b1;
            wr_o.addr = {row_q, col_q};
            wr_o.data = in_byte_i;
            placed_d  = placed_inc;
            if (col_q == SideLast) begin
              col_d = '0;
              row_d = row_q + 3'd1;
            end else begin
              col_d = col_q + 3'd1;
            end
            if (placed_inc >= Total) begin
              s_rot_d = '0;
              s_pos_d = '0;
              n_d     = '0;
              state_d = ST_DEC_EMIT;
            end
          end
        end
      end

      ST_ENC_SCAN: begin
        if (scan_i.hit) begin
          wr_o.en   = 1'b1;
          wr_o.addr = scan_i.pos;
          wr_o.data = byte_q;
          placed_d  = placed_inc;
          pos_d     = scan_i.pos + 6'd1;
          rot_d     = (scan_i.pos == POS_LAST) ? s_rot_q + 2'd1 : s_rot_q;
          if (placed_inc >= CellsMax || !scan_i.more) begin
            row_d   = '0;
            col_d   = '0;
            state_d = ST_ENC_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (s_rot_q == ROT_LAST) begin
          state_d = ST_IDLE;
        end else begin
          s_rot_d = s_rot_q + 2'd1;
          s_pos_d = '0;
        end
      end

      ST_PAD_SCAN: begin
        if (placed_q >= CellsMax) begin
          row_d   = '0;
          col_d   = '0;
          state_d = ST_ENC_EMIT;
        end else if (scan_i.hit) begin
          pad_addr_d = scan_i.pos;
          pad_more_d = scan_i.more;
          pos_d      = scan_i.pos + 6'd1;
          rot_d      = (scan_i.pos == POS_LAST) ? s_rot_q + 2'd1 : s_rot_q;
          pad_step_o = 1'b1;
          state_d    = ST_PAD_WRITE;
        end else if (s_rot_q == ROT_LAST) begin
          row_d   = '0;
          col_d   = '0;
          state_d = ST_ENC_EMIT;
        end else begin
          s_rot_d = s_rot_q + 2'd1;
          s_pos_d = '0;
        end
      end

      ST_PAD_WRITE: begin
        wr_o.en   = 1'b1;
        wr_o.addr = pad_addr_q;
        wr_o.data = pad_letter_i;
        placed_d  = placed_inc;
        if (placed_inc >= CellsMax || !pad_more_q) begin
          row_d   = '0;
          col_d   = '0;
          state_d = ST_ENC_EMIT;
        end else begin
          s_rot_d = rot_q;
          s_pos_d = pos_q;
          state_d = ST_PAD_SCAN;
        end
      end

      ST_ENC_EMIT: begin
        if (slot_free) begin
          rd_o.en     = 1'b1;
          rd_o.addr   = {row_q, col_q};
          out_valid_d = 1'b1;
          out_idx_d   = {row_q, col_q};
          out_last_d  = grid_last;
          if (col_q == SideLast) begin
            col_d = '0;
            row_d = row_q + 3'd1;
          end else begin
            col_d = col_q + 3'd1;
          end
          if (grid_last) begin
            clear_o  = 1'b1;
            rot_d    = '0;
            pos_d    = '0;
            placed_d = '0;
            row_d    = '0;
            col_d    = '0;
            state_d  = ST_IDLE;
          end
        end
      end

      ST_DEC_EMIT: begin
        if (scan_i.hit) begin
          if (slot_free) begin
            rd_o.en     = 1'b1;
            rd_o.addr   = scan_i.pos;
            out_valid_d = 1'b1;
            out_idx_d   = n_q;
            out_last_d  = dec_last;
            n_d         = n_q + 6'd1;
            s_pos_d     = scan_i.pos + 6'd1;
            s_rot_d     = (scan_i.pos == POS_LAST) ? s_rot_q + 2'd1 : s_rot_q;
            if (dec_last) begin
              clear_o  = 1'b1;
              rot_d    = '0;
              pos_d    = '0;
              placed_d = '0;
              row_d    = '0;
              col_d    = '0;
              state_d  = ST_IDLE;
            end
          end
        end else if (s_rot_q == ROT_LAST) begin
          clear_o  = 1'b1;
          rot_d    = '0;
          pos_d    = '0;
          placed_d = '0;
          row_d    = '0;
          col_d    = '0;
          state_d  = ST_IDLE;
        end else begin
          s_rot_d = s_rot_q + 2'd1;
          s_pos_d = '0;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i && cfg_idx_i == CFG_MODE) begin
      mode_d   = cfg_data_i[0];
      clear_o  = 1'b1;
      rot_d    = '0;
      pos_d    = '0;
      placed_d = '0;
      row_d    = '0;
      col_d    = '0;
    end
    if (cfg_we_i && cfg_idx_i == CFG_MASK) begin
      mask_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_ENC;
      mask_q      <= HOLE_MASK_RESET;
      byte_q      <= '0;
      rot_q       <= '0;
      pos_q       <= '0;
      placed_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      s_rot_q     <= '0;
      s_pos_q     <= '0;
      pad_addr_q  <= '0;
      pad_more_q  <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      mask_q      <= mask_d;
      byte_q      <= byte_d;
      rot_q       <= rot_d;
      pos_q       <= pos_d;
      placed_q    <= placed_d;
      row_q       <= row_d;
      col_q       <= col_d;
      s_rot_q     <= s_rot_d;
      s_pos_q     <= s_pos_d;
      pad_addr_q  <= pad_addr_d;
      pad_more_q  <= pad_more_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_last_q  <= out_last_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_index_o = out_idx_q;
  assign out_last_o  = out_last_q;
  assign mask_o      = mask_q;
  assign scan_rot_o  = s_rot_q;
  assign scan_pos_o  = s_pos_q;
  assign pad_load_o  = cfg_we_i && (cfg_idx_i == CFG_SEED);
  assign pad_seed_o  = cfg_data_i[31:0];

endmodule

[rtl/core/turning_grille_cipher.sv]
// Top level of the turning-grille transposition cipher.
// Depends on tgc_pkg, tgc_store, tgc_scan, tgc_pad and tgc_ctrl.
//
//   channel  | direction | tdata / fields                       | tuser / tlast
//   s_axis   | in        | [7:0] data_byte                      | tuser: action
//   m_axis   | out       | [7:0] out_byte, [13:8] out_index     | tlast: last
//   cfg      | in        | cfg_idx_i 0 mode, 1 hole mask, 2 pad seed; cfg_data_i value
//
// Data byte, encrypt: accepted, then scanned one rotation per cycle through the hole scan until
// a hole is found, and written to the cell store at that hole; with no hole, no write.
// Finish, encrypt: each padding letter takes a scan in ST_PAD_SCAN and a write in ST_PAD_WRITE,
// then the GRID_SIDE*GRID_SIDE cells are emitted, one read of the cell store per result.
// Decrypt: cells written as accepted; emission one result per cycle, bar stalls and rotation steps.
// Reset clears control state and the store's valid bits at once; no sweep.
// The output register takes back-pressure; a new transaction is accepted while the last
// result still waits, but not during placement, padding or emission.
module turning_grille_cipher
  import tgc_pkg::*;
#(
  parameter int unsigned GRID_SIDE = TGC_GRID_SIDE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [13:8] out_index, [15:14] zero
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] mask;
  logic [1:0]  scan_rot;
  logic [5:0]  scan_pos;
  scan_t       scan;
  mem_wr_t     wr;
  rd_req_t     rd;
  logic        clear;
  logic        pad_load;
  logic [31:0] pad_seed;
  logic        pad_step;
  logic [7:0]  pad_letter;
  logic [7:0]  rd_data;
  logic [5:0]  out_index;

  tgc_ctrl #(
    .GRID_SIDE(GRID_SIDE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (out_index),
    .out_last_o  (m_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .mask_o      (mask),
    .scan_rot_o  (scan_rot),
    .scan_pos_o  (scan_pos),
    .scan_i      (scan),
    .wr_o        (wr),
    .clear_o     (clear),
    .rd_o        (rd),
    .pad_load_o  (pad_load),
    .pad_seed_o  (pad_seed),
    .pad_step_o  (pad_step),
    .pad_letter_i(pad_letter)
  );

  tgc_scan #(
    .GRID_SIDE(GRID_SIDE)
  ) u_scan (
    .mask_i(mask),
    .rot_i (scan_rot),
    .pos_i (scan_pos),
    .scan_o(scan)
  );

  tgc_pad u_pad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (pad_load),
    .seed_i  (pad_seed),
    .step_i  (pad_step),
    .letter_o(pad_letter)
  );

  tgc_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .clear_i  (clear),
    .rd_i     (rd),
    .rd_data_o(rd_data)
  );

  assign m_axis_tdata = {2'b00, out_index, rd_data};

endmodule

[rtl/core/tgc_checker.sv]
// Port-level checks of the turning-grille cipher, bound to the top level.
// Depends on turning_grille_cipher.
module tgc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [63:0] cfg_data_i
);

  logic unused_ok;
  assign unused_ok = ^{s_axis_tdata, s_axis_tuser, cfg_we_i, cfg_idx_i, cfg_data_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:14] == 2'b00 || unused_ok != unused_ok))
    else $error("tdata fill bits not zero");

  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("ready dropped without an accepted transaction");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("block not quiet after reset");

endmodule

bind turning_grille_cipher tgc_checker u_checker (.*);

[tb/sv/tb_turning_grille_cipher.sv]
// Self-checking testbench of the turning-grille cipher: random stream traffic in both
// modes with an in-bench predictor of the grid and message bytes.
// Depends on tgc_pkg and turning_grille_cipher.
module tb_turning_grille_cipher;
  import tgc_pkg::*;

  localparam int unsigned TURNS         = 4;
  localparam int unsigned LETTERS       = 26;
  localparam logic [1:0]  CFG_UNUSED    = 2'd3;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } grille_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [5:0] out_index;
    logic       last;
  } grille_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = ACT_DATA;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CFG_MODE;
  logic [63:0] cfg_data_i    = '0;

  turning_grille_cipher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state and register copies
  logic        mode_q  = MODE_ENC;
  logic [63:0] holes_q = HOLE_MASK_RESET;
  logic [31:0] pad_reg = PAD_SEED_RESET;
  logic [7:0]  grid_cells [NUM_CELLS];
  int unsigned turn_idx, scan_pos, cells_placed;

  grille_item_t   input_backlog [$];
  grille_result_t cipher_bytes_due [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int stall_reqs   = 0;
  int stalls_done  = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int items_queued = 0;
  int items_in     = 0;
  int results_seen = 0;
  int emissions    = 0;
  int reg_writes   = 0;
  int mismatches   = 0;

  function automatic void clear_run();
    foreach (grid_cells[p]) grid_cells[p] = 8'h00;
    turn_idx     = 0;
    scan_pos     = 0;
    cells_placed = 0;
  endfunction

  function automatic bit is_hole(int unsigned turn, int unsigned p);
    int unsigned r, c, nr;
    r = p >> 3;
    c = p & 7;
    for (int unsigned k = 0; k < turn; k++) begin
      nr = TGC_GRID_SIDE - 1 - c;
      c  = r;
      r  = nr;
    end
    return holes_q[r * 8 + c];
  endfunction

  function automatic bit find_hole(output int unsigned ft, output int unsigned fp);
    int unsigned p0;
    for (int unsigned t = turn_idx; t < TURNS; t++) begin
      p0 = (t == turn_idx) ? scan_pos : 0;
      for (int unsigned p = p0; p < NUM_CELLS; p++) begin
        if (is_hole(t, p)) begin
          ft = t;
          fp = p;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic bit step_past(int unsigned ft, int unsigned fp);
    if (fp < NUM_CELLS - 1) begin
      turn_idx = ft;
      scan_pos = fp + 1;
      return 1'b1;
    end
    if (ft < TURNS - 1) begin
      turn_idx = ft + 1;
      scan_pos = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_due(logic [7:0] b, logic [5:0] idx, logic fin);
    grille_result_t r;
    r.out_byte  = b;
    r.out_index = idx;
    r.last      = fin;
    cipher_bytes_due.push_back(r);
  endfunction

  function automatic void emit_grid();
    for (int p = 0; p < NUM_CELLS; p++) push_due(grid_cells[p], 6'(p), p == NUM_CELLS - 1);
    clear_run();
  endfunction

  function automatic void emit_message();
    logic [5:0] order [$];
    for (int unsigned t = 0; t < TURNS; t++)
      for (int unsigned p = 0; p < NUM_CELLS; p++)
        if (order.size() < NUM_CELLS && is_hole(t, p)) order.push_back(6'(p));
    foreach (order[n]) push_due(grid_cells[order[n]], 6'(n), n == order.size() - 1);
    clear_run();
  endfunction

  function automatic void grille_step(logic action, logic [7:0] raw);
    int unsigned ft, fp;
    logic [7:0]  b;
    logic        lsb;
    b = raw;
    if (mode_q == MODE_ENC && action == ACT_FINISH) begin
      while (cells_placed < NUM_CELLS && find_hole(ft, fp)) begin
        if (pad_reg == 0) pad_reg = 32'd1;
        lsb     = pad_reg[0];
        pad_reg = pad_reg >> 1;
        if (lsb) pad_reg = pad_reg ^ PAD_TAPS;
        grid_cells[fp] = CHR_LOWER_A + 8'(pad_reg % LETTERS);
        cells_placed++;
        if (!step_past(ft, fp)) break;
      end
      emit_grid();
    end else if (mode_q == MODE_ENC) begin
      // drop whitespace and punctuation, lowercase capitals
      if (b inside {[8'h09:8'h0D], [8'h20:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60],
                    [8'h7B:8'h7E]})
        return;
      if (b inside {[8'h41:8'h5A]}) b = b + 8'h20;
      if (!find_hole(ft, fp)) return;
      grid_cells[fp] = b;
      cells_placed++;
      if (!step_past(ft, fp) || cells_placed >= NUM_CELLS || !find_hole(ft, fp)) emit_grid();
    end else if (action == ACT_FINISH) begin
      emit_message();
    end else begin
      if (cells_placed < NUM_CELLS) begin
        grid_cells[cells_placed] = b;
        cells_placed++;
      end
      if (cells_placed >= NUM_CELLS) emit_message();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : item_driver
    grille_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        grille_step(s_axis_tuser, s_axis_tdata);
        items_in++;
      end
      // hold the offered transaction until it is taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (input_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt = input_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.action;
          s_axis_tdata  <= nxt.data_byte;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    grille_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tlast) emissions++;
        if (cipher_bytes_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual byte %h index %0d last %b",
                   $time, m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tlast);
        end else begin
          want = cipher_bytes_due.pop_front();
          if (m_axis_tdata[7:0] !== want.out_byte) begin
            mismatches++;
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     m_axis_tdata[7:0]);
          end
          if (m_axis_tdata[13:8] !== want.out_index) begin
            mismatches++;
            $display("%0t: out_index expected %0d actual %0d", $time, want.out_index,
                     m_axis_tdata[13:8]);
          end
          if (m_axis_tlast !== want.last) begin
            mismatches++;
            $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
          end
        end
      end
      if (stalls_done != stall_reqs) begin
        stalls_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, cipher_bytes_due.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(logic action, logic [7:0] b);
    grille_item_t it;
    it.action    = action;
    it.data_byte = b;
    input_backlog.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (input_backlog.size() != 0 || s_axis_tvalid || cipher_bytes_due.size() != 0);
  endtask

  task automatic apply_reg(logic [1:0] idx, logic [63:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_MODE: begin
        mode_q = value[0];
        clear_run();
      end
      CFG_MASK: holes_q = value;
      CFG_SEED: pad_reg = value[31:0];
      default: ;
    endcase
  endtask

  task automatic queue_message(int len, bit with_finish);
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)      queue_item(ACT_DATA, 8'(8'h61 + $urandom_range(25)));
      else if (pick < 65) queue_item(ACT_DATA, 8'(8'h41 + $urandom_range(25)));
      else if (pick < 75) queue_item(ACT_DATA, 8'(8'h30 + $urandom_range(9)));
      else if (pick < 88) queue_item(ACT_DATA, 8'($urandom_range(8'h2F, 8'h20)));
      else                queue_item(ACT_DATA, 8'($urandom_range(255)));
    end
    if (with_finish) queue_item(ACT_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic queue_grid(int cells);
    for (int i = 0; i < cells; i++) queue_item(ACT_DATA, 8'($urandom_range(255)));
    if (cells < NUM_CELLS) queue_item(ACT_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic random_phase(logic mode, logic [63:0] mask, logic [31:0] seed, int n);
    int goal;
    apply_reg(CFG_MODE, {63'd0, mode});
    apply_reg(CFG_MASK, mask);
    apply_reg(CFG_SEED, {32'd0, seed});
    goal = items_queued + n;
    while (items_queued < goal) begin
      if (mode == MODE_ENC) queue_message($urandom_range(70), $urandom_range(3) != 0);
      else queue_grid(($urandom_range(3) == 0) ? NUM_CELLS : $urandom_range(40));
    end
  endtask

  initial begin
    logic [7:0]  opening [15];
    logic [63:0] sparse;
    opening = '{8'h48, 8'h69, 8'h2C, 8'h20, 8'h09, 8'h0D, 8'h5A, 8'h60, 8'h7B, 8'h7E,
                8'h40, 8'h00, 8'h7F, 8'hFF, 8'h80};
    clear_run();
    snd_idle_pct = 20;
    rcv_idle_pct = 61;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // mixed message bytes, then a finish and a finish on an empty grid
    foreach (opening[i]) queue_item(ACT_DATA, opening[i]);
    queue_item(ACT_FINISH, 8'h00);
    queue_item(ACT_FINISH, 8'hFF);
    apply_reg(CFG_MODE, {63'd0, MODE_DEC});
    queue_item(ACT_DATA, 8'h00);
    queue_item(ACT_DATA, 8'hFF);
    queue_item(ACT_FINISH, 8'h00);
    queue_item(ACT_FINISH, 8'h00);
    // no holes at all
    apply_reg(CFG_MASK, 64'd0);
    queue_item(ACT_DATA, 8'h5A);
    queue_item(ACT_FINISH, 8'h00);
    apply_reg(CFG_MODE, {63'd0, MODE_ENC});
    queue_item(ACT_DATA, 8'h71);
    queue_item(ACT_FINISH, 8'h00);
    // every cell a hole, zero seed
    apply_reg(CFG_MASK, '1);
    apply_reg(CFG_SEED, 64'd0);
    apply_reg(CFG_UNUSED, '1);
    queue_item(ACT_FINISH, 8'h00);

    random_phase(MODE_ENC, HOLE_MASK_RESET, $urandom | 32'd1, 5);
    // back up the output while messages keep arriving
    stall_reqs++;
    queue_message(20, 1'b1);
    queue_message(10, 1'b1);
    wait_drained();
    queue_message(10, 1'b1);
    random_phase(MODE_DEC, {$urandom, $urandom}, $urandom | 32'd1, 5);

    snd_idle_pct = 61;
    rcv_idle_pct = 20;
    random_phase(MODE_ENC, {$urandom, $urandom}, 32'hFFFF_FFFF, 5);
    sparse = '0;
    repeat ($urandom_range(5, 1)) sparse[$urandom_range(63)] = 1'b1;
    random_phase(MODE_DEC, sparse, $urandom | 32'd1, 5);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_phase(MODE_ENC, '1, $urandom | 32'd1, 5);
    random_phase(MODE_DEC, HOLE_MASK_RESET, PAD_SEED_RESET, 5);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d input transactions and %0d register writes in both modes,",
             items_in, reg_writes);
    $display("checking %0d output bytes over %0d grids and messages.", results_seen,
             emissions);
    if (mismatches == 0 && cipher_bytes_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/tgc_pkg.sv
rtl/core/tgc_store.sv
rtl/core/tgc_scan.sv
rtl/core/tgc_pad.sv
rtl/core/tgc_ctrl.sv
rtl/core/turning_grille_cipher.sv
rtl/core/tgc_checker.sv
tb/sv/tb_turning_grille_cipher.sv
